[hdl/fcct_pkg.sv]
// ----------------------------------------------------------------------------
// fcct_pkg: shared types and constants for the cluster chain table
// Field widths, request and status codes, link constants, reset image.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fcct_pkg;

  // table geometry
  localparam int unsigned TableEntries = 4096;
  localparam int unsigned IdxW         = $clog2(TableEntries);
  localparam int unsigned CntW         = IdxW + 1;

  // word field widths
  localparam int unsigned ReqW     = 2;
  localparam int unsigned ClusterW = 12;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned LinkW    = 28;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned FreedW   = 13;
  localparam int unsigned TotalW   = 12;

  // configuration port
  localparam int unsigned PAddrW = 3;
  localparam int unsigned PDataW = 32;

  // register word index (paddr[2])
  localparam logic RegTotalClusters = 1'b0;
  localparam logic [TotalW-1:0] TotalReset = TotalW'(4094);

  // link codes
  localparam logic [LinkW-1:0] LinkEoc    = 28'hFFF_FFFF;
  localparam logic [LinkW-1:0] LinkBadMin = 28'hFFF_FFF8;
  localparam logic [LinkW-1:0] LinkMedia  = 28'hFFF_FFF8;
  localparam logic [LinkW-1:0] LinkFree   = '0;

  typedef enum logic [ReqW-1:0] {
    REQ_READ  = 2'd0,
    REQ_SET   = 2'd1,
    REQ_ALLOC = 2'd2,
    REQ_FREE  = 2'd3
  } req_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_RANGE  = 2'd2,
    ST_LIMIT  = 2'd3
  } status_e;

  // freshly formatted table contents
  function automatic logic [LinkW-1:0] init_link(input logic [IdxW-1:0] idx);
    logic [LinkW-1:0] v;
    v = LinkFree;
    if (idx == IdxW'(0)) begin
      v = LinkMedia;
    end else if (idx == IdxW'(1) || idx == IdxW'(2)) begin
      v = LinkEoc;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

[hdl/fcct_if.sv]
// ----------------------------------------------------------------------------
// fcct_req_if / fcct_rsp_if: valid/ready channels of the chain table
// Request and response words with their handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fcct_req_if;
  logic                          valid;
  logic                          ready;
  logic [fcct_pkg::ReqW-1:0]     req_type;
  logic [fcct_pkg::ClusterW-1:0] cluster_index;
  logic [fcct_pkg::ValueW-1:0]   link_value;

  modport source (output valid, req_type, cluster_index, link_value, input ready);
  modport sink   (input valid, req_type, cluster_index, link_value, output ready);
endinterface

interface fcct_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [fcct_pkg::LinkW-1:0]   result_value;
  logic [fcct_pkg::StatusW-1:0] status;
  logic [fcct_pkg::FreedW-1:0]  freed_count;

  modport source (output valid, result_value, status, freed_count, input ready);
  modport sink   (input valid, result_value, status, freed_count, output ready);
endinterface

`default_nettype wire

[hdl/fcct_link_ram.sv]
// ----------------------------------------------------------------------------
// fcct_link_ram: link table storage
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcct_link_ram #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned Width = 28,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hdl/fat_cluster_chain_table_unit.sv]
// Steps: read loads the RAM, then captures its data; set writes the entry; allocate
//   loads and checks each cluster searched; free checks and clears each chain entry.
// Flow: one request at a time; the link RAM and one compare unit are stepped
//   by the sequencer; a held response word keeps the sequencer waiting and
//   request ready low.
// Reset: a pass writes the formatted table image into the RAM, request ready
//   stays low until it ends; config writes are taken always.
// ----------------------------------------------------------------------------
// fat_cluster_chain_table_unit: on-chip cluster allocation table
// Read, set, first-fit allocate and chain free over a 4096 x 28 link RAM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fat_cluster_chain_table_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  fcct_req_if.sink                         req_i,
  fcct_rsp_if.source                       rsp_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [fcct_pkg::PAddrW-1:0] paddr,
  input  wire logic [fcct_pkg::PDataW-1:0] pwdata,
  output logic      [fcct_pkg::PDataW-1:0] prdata,
  output logic                             pready
);

  localparam int unsigned IdxW  = fcct_pkg::IdxW;
  localparam int unsigned LinkW = fcct_pkg::LinkW;
  localparam int unsigned CntW  = fcct_pkg::CntW;

  typedef enum logic [9:0] {
    S_INIT  = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_RLD   = 10'b00_0000_0100,
    S_RDAT  = 10'b00_0000_1000,
    S_SET   = 10'b00_0001_0000,
    S_ALOAD = 10'b00_0010_0000,
    S_ACHK  = 10'b00_0100_0000,
    S_WCHK  = 10'b00_1000_0000,
    S_WRD   = 10'b01_0000_0000,
    S_RESP  = 10'b10_0000_0000
  } state_e;

  state_e                         state_q, state_d;
  logic [IdxW-1:0]                clr_q, clr_d;
  logic [LinkW-1:0]               cur_q, cur_d;
  logic [LinkW-1:0]               setv_q, setv_d;
  logic [IdxW-1:0]                last_q, last_d;
  logic [LinkW-1:0]               res_q, res_d;
  fcct_pkg::status_e              st_q, st_d;
  logic [CntW-1:0]                freed_q, freed_d;
  logic [fcct_pkg::TotalW-1:0]    total_q;

  logic                           out_valid_q;
  logic [LinkW-1:0]               out_res_q;
  logic [fcct_pkg::StatusW-1:0]   out_st_q;
  logic [fcct_pkg::FreedW-1:0]    out_freed_q;
  logic                           out_load;

  logic                           ram_we, ram_re;
  logic [IdxW-1:0]                ram_waddr;
  logic [LinkW-1:0]               ram_wdata, ram_rdata;

  logic                           in_fire, idx_ok, cfg_we;
  logic [fcct_pkg::TotalW:0]      total_p1;
  logic                           cur_goes_on, cur_out, freed_full, last_hit, slot_free;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == fcct_pkg::RegTotalClusters)
                ? fcct_pkg::PDataW'(total_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= fcct_pkg::TotalReset;
    end else if (cfg_we && paddr[2] == fcct_pkg::RegTotalClusters) begin
      total_q <= pwdata[fcct_pkg::TotalW-1:0];
    end
  end

  // ---------------- link RAM ----------------
  fcct_link_ram #(
    .Depth (fcct_pkg::TableEntries),
    .Width (LinkW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cur_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  // ---------------- shared compare unit ----------------
  assign in_fire     = req_i.valid && req_i.ready;
  assign idx_ok      = 32'(req_i.cluster_index) < fcct_pkg::TableEntries;
  assign total_p1    = {1'b0, total_q} + 1'b1;
  assign cur_goes_on = (cur_q != fcct_pkg::LinkFree) && (cur_q < fcct_pkg::LinkBadMin);
  assign cur_out     = 32'(cur_q) >= fcct_pkg::TableEntries;
  assign freed_full  = 32'(freed_q) >= fcct_pkg::TableEntries;
  assign last_hit    = cur_q[IdxW-1:0] == last_q;
  assign slot_free   = !out_valid_q || rsp_o.ready;

  assign req_i.ready = (state_q == S_IDLE);

  // RAM port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_q[IdxW-1:0];
    ram_wdata = fcct_pkg::LinkFree;
    ram_re    = 1'b0;
    unique case (state_q) inside
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = fcct_pkg::init_link(clr_q);
      end
      S_SET: begin
        ram_we    = 1'b1;
        ram_wdata = setv_q;
      end
      S_ACHK: begin
        ram_we    = (ram_rdata == fcct_pkg::LinkFree);
        ram_wdata = fcct_pkg::LinkEoc;
      end
      S_WRD: begin
        ram_we    = 1'b1;
      end
      S_RLD, S_ALOAD, S_WCHK: begin
        ram_re    = 1'b1;
      end
      default: begin
        ram_we    = 1'b0;
      end
    endcase
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    cur_d    = cur_q;
    setv_d   = setv_q;
    last_d   = last_q;
    res_d    = res_q;
    st_d     = st_q;
    freed_d  = freed_q;
    out_load = 1'b0;
    unique case (state_q)
      S_INIT: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == IdxW'(fcct_pkg::TableEntries - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          cur_d   = LinkW'(req_i.cluster_index);
          setv_d  = req_i.link_value[LinkW-1:0];
          res_d   = '0;
          st_d    = fcct_pkg::ST_OK;
          freed_d = '0;
          if (32'(total_p1) > fcct_pkg::TableEntries - 1) begin
            last_d = IdxW'(fcct_pkg::TableEntries - 1);
          end else begin
            last_d = IdxW'(total_p1);
          end
          unique case (fcct_pkg::req_e'(req_i.req_type)) inside
            fcct_pkg::REQ_READ, fcct_pkg::REQ_SET: begin
              if (!idx_ok) begin
                st_d    = fcct_pkg::ST_RANGE;
                state_d = S_RESP;
              end else if (req_i.req_type == fcct_pkg::REQ_READ) begin
                state_d = S_RLD;
              end else begin
                state_d = S_SET;
              end
            end
            fcct_pkg::REQ_ALLOC: begin
              cur_d = LinkW'(2);
              if (total_q == '0) begin
                st_d    = fcct_pkg::ST_NOFREE;
                state_d = S_RESP;
              end else begin
                state_d = S_ALOAD;
              end
            end
            fcct_pkg::REQ_FREE: begin
              state_d = S_WCHK;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_RLD: begin
        state_d = S_RDAT;
      end
      S_RDAT: begin
        res_d   = ram_rdata;
        state_d = S_RESP;
      end
      S_SET: begin
        state_d = S_RESP;
      end
      S_ALOAD: begin
        state_d = S_ACHK;
      end
      S_ACHK: begin
        // first zero link wins; RAM write of end-of-chain happens here
        if (ram_rdata == fcct_pkg::LinkFree) begin
          res_d   = cur_q;
          state_d = S_RESP;
        end else if (last_hit) begin
          st_d    = fcct_pkg::ST_NOFREE;
          state_d = S_RESP;
        end else begin
          cur_d   = cur_q + 1'b1;
          state_d = S_ALOAD;
        end
      end
      S_WCHK: begin
        if (!cur_goes_on) begin
          state_d = S_RESP;
        end else if (cur_out) begin
          st_d    = fcct_pkg::ST_RANGE;
          state_d = S_RESP;
        end else if (freed_full) begin
          st_d    = fcct_pkg::ST_LIMIT;
          state_d = S_RESP;
        end else begin
          state_d = S_WRD;
        end
      end
      S_WRD: begin
        // entry cleared this cycle, follow its old link
        cur_d   = ram_rdata;
        freed_d = freed_q + 1'b1;
        state_d = S_WCHK;
      end
      S_RESP: begin
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    setv_q  <= setv_d;
    last_q  <= last_d;
    res_q   <= res_d;
    st_q    <= st_d;
    freed_q <= freed_d;
  end

  // ---------------- response word register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_res_q   <= res_q;
      out_st_q    <= st_q;
      out_freed_q <= fcct_pkg::FreedW'(freed_q);
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.result_value = out_res_q;
  assign rsp_o.status       = out_st_q;
  assign rsp_o.freed_count  = out_freed_q;

  // ---------------- assertions ----------------
  a_init_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT) |-> !req_i.ready)
    else $error("request accepted during table clearing pass");

  a_freed_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WCHK) |-> (32'(freed_q) <= fcct_pkg::TableEntries))
    else $error("free walk count past table size");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACHK) |-> (cur_q[IdxW-1:0] <= last_q && cur_q >= LinkW'(2)))
    else $error("allocation scan left its window");

  a_load_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> ((state_q == S_RESP) && slot_free))
    else $error("response word loaded outside response step");

  a_nofree_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == fcct_pkg::ST_NOFREE) |-> (rsp_o.result_value == '0))
    else $error("no-free status with nonzero cluster number");

endmodule

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for fat_cluster_chain_table_unit
// Drives read, set, allocate and chain-free requests with random gaps on both
// channels. A shadow copy of the link table predicts every response word, and
// the cluster count register is reprogrammed over APB between traffic phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import fcct_pkg::*;

  // traffic shape
  localparam int unsigned PhaseCount    = 8;
  localparam int unsigned ItemsPerPhase = 170;
  localparam int unsigned ShortChainMax = 12;
  localparam int unsigned LongChain     = 300;
  localparam int unsigned HoldPhase     = 2;
  localparam int unsigned PausePhase    = 4;
  localparam int unsigned HoldCycles    = 400;
  // drain guard, covering a full-table walk plus receiver stalls
  localparam int unsigned DrainGuard    = 50000;
  localparam int unsigned TailCycles    = 16;

  typedef struct packed {
    logic [LinkW-1:0]  value;
    status_e           status;
    logic [FreedW-1:0] freed;
  } rsp_word_t;

  // Shadow link table plus the queue of response words it predicts
  class cluster_table_shadow;
    logic [LinkW-1:0]  links [TableEntries];
    logic [TotalW-1:0] cluster_limit;
    rsp_word_t         pending_words [$];
    int unsigned       mismatches;
    int unsigned       words_checked;
    int unsigned       kind_seen [1 << ReqW];
    int unsigned       status_seen [1 << StatusW];
    int unsigned       longest_free;

    function new();
      int unsigned i;
      for (i = 0; i < TableEntries; i++) begin
        links[i] = LinkFree;
      end
      // formatted table: media entry, then two end-of-chain markers
      links[0] = LinkMedia;
      links[1] = LinkEoc;
      links[2] = LinkEoc;
      cluster_limit = TotalReset;
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] mismatch: %s", $time, what);
      end
    endfunction

    // apply one accepted request word and queue the response it must produce
    function void accept_request(req_e kind, logic [ClusterW-1:0] index,
                                 logic [ValueW-1:0] value);
      rsp_word_t        exp;
      int unsigned      c;
      int unsigned      last;
      int unsigned      freed;
      logic [LinkW-1:0] cur;
      logic [LinkW-1:0] nxt;
      bit               walking;
      exp.value  = LinkFree;
      exp.status = ST_OK;
      exp.freed  = '0;
      freed      = 0;
      case (kind)
        REQ_READ: begin
          if (index < TableEntries) begin
            exp.value = links[index];
          end else begin
            exp.status = ST_RANGE;
          end
        end
        REQ_SET: begin
          if (index < TableEntries) begin
            links[index] = value[LinkW-1:0];
          end else begin
            exp.status = ST_RANGE;
          end
        end
        REQ_ALLOC: begin
          // first fit over 2 .. limit+1, clipped to the table
          last = cluster_limit + 2;
          if (last > TableEntries) begin
            last = TableEntries;
          end
          exp.status = ST_NOFREE;
          for (c = 2; c < last; c++) begin
            if (exp.status == ST_NOFREE && links[c] == LinkFree) begin
              links[c]   = LinkEoc;
              exp.value  = LinkW'(c);
              exp.status = ST_OK;
            end
          end
        end
        default: begin
          // chain free: clear until 0, end-of-chain or a bad/reserved code.
          // The walk limit cannot trip with this table size: cluster 0 and a
          // cleared entry both end a walk, so at most TableEntries-1 distinct
          // entries and one revisit are cleared.
          cur     = LinkW'(index);
          walking = 1'b1;
          while (walking && cur != LinkFree && cur != LinkEoc && cur < LinkBadMin) begin
            if (cur >= TableEntries) begin
              exp.status = ST_RANGE;
              walking    = 1'b0;
            end else if (freed >= TableEntries) begin
              exp.status = ST_LIMIT;
              walking    = 1'b0;
            end else begin
              nxt                    = links[cur[IdxW-1:0]];
              links[cur[IdxW-1:0]]   = LinkFree;
              freed++;
              cur = nxt;
            end
          end
          exp.freed = FreedW'(freed);
          if (freed > longest_free) begin
            longest_free = freed;
          end
        end
      endcase
      kind_seen[kind]++;
      status_seen[exp.status]++;
      pending_words.push_back(exp);
    endfunction

    // compare one accepted response word with the oldest prediction
    function void compare_word(logic [LinkW-1:0] value, logic [StatusW-1:0] status,
                               logic [FreedW-1:0] freed);
      rsp_word_t exp;
      if (pending_words.size() == 0) begin
        flag($sformatf("unexpected word value %h status %0d freed %0d",
                       value, status, freed));
        return;
      end
      exp = pending_words.pop_front();
      words_checked++;
      if (value !== exp.value || status !== exp.status || freed !== exp.freed) begin
        flag($sformatf("expected value %h status %0d freed %0d, got value %h status %0d freed %0d",
                       exp.value, exp.status, exp.freed, value, status, freed));
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PAddrW-1:0] paddr;
  logic [PDataW-1:0] pwdata;
  logic [PDataW-1:0] prdata;
  logic              pready;

  fcct_req_if req_if ();
  fcct_rsp_if rsp_if ();

  cluster_table_shadow shadow;

  int unsigned items_sent;
  int unsigned req_gap_pct;
  int unsigned rsp_idle_pct;
  int unsigned rsp_hold_len;
  int unsigned holdoffs_done;
  bit          all_drained;

  fat_cluster_chain_table_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(16, 60) : $urandom_range(1, 3);
  endfunction

  // Offer one request word, holding it until the block takes it
  task automatic offer_request(input req_e kind, input logic [ClusterW-1:0] index,
                               input logic [ValueW-1:0] value);
    int unsigned gap;
    if ($urandom_range(0, 99) < req_gap_pct) begin
      gap = pick_gap();
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.req_type      <= kind;
    req_if.cluster_index <= index;
    req_if.link_value    <= value;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    shadow.accept_request(kind, index, value);
    items_sent++;
  endtask

  // Stop offering and wait for every predicted word, with a guard
  task automatic wait_for_all_words(output bit drained);
    int unsigned waited;
    waited = 0;
    req_if.valid <= 1'b0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (shadow.pending_words.size() != 0 && waited < DrainGuard);
    drained = (shadow.pending_words.size() == 0);
  endtask

  // APB write of the cluster count register, then read it back
  task automatic program_total(input logic [TotalW-1:0] total);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PAddrW'({RegTotalClusters, 2'b00});
    pwdata  <= PDataW'(total);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    shadow.cluster_limit = total;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata !== PDataW'(total)) begin
      shadow.flag($sformatf("cluster count read back %h, wrote %h", prdata, total));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Link a set of clusters into a chain, maybe peek at one, then free it
  task automatic build_and_free_chain(input int unsigned len);
    logic [ClusterW-1:0] members [$];
    logic [LinkW-1:0]    tail;
    logic [LinkW-1:0]    next_link;
    int unsigned         base;
    int unsigned         i;
    base = $urandom_range(0, TableEntries - 2);
    for (i = 0; i < len; i++) begin
      // long chains use distinct clusters so the walk really goes deep
      if (len > ShortChainMax) begin
        members.push_back(ClusterW'(1 + (base + i) % (TableEntries - 1)));
      end else begin
        members.push_back(ClusterW'($urandom_range(1, TableEntries - 1)));
      end
    end
    case ($urandom_range(0, 5))
      0: tail = LinkEoc;
      1: tail = LinkFree;
      2: tail = LinkBadMin + LinkW'($urandom_range(0, 6));
      3: tail = LinkW'($urandom_range(TableEntries, 32'h0FFF_FFF7));
      4: tail = LinkW'(members[$urandom_range(0, len - 1)]);
      default: tail = LinkW'($urandom());
    endcase
    for (i = 0; i < len; i++) begin
      next_link = (i + 1 < len) ? LinkW'(members[i + 1]) : tail;
      offer_request(REQ_SET, members[i], {4'($urandom()), next_link});
    end
    if ($urandom_range(0, 1) == 1) begin
      offer_request(REQ_READ, members[$urandom_range(0, len - 1)], $urandom());
    end
    offer_request(REQ_FREE, members[0], $urandom());
  endtask

  // Hand-picked opening sequence on the freshly formatted table
  task automatic run_directed_checks();
    // formatted entries and both ends of the index range
    offer_request(REQ_READ, ClusterW'(0), '0);
    offer_request(REQ_READ, ClusterW'(1), '0);
    offer_request(REQ_READ, ClusterW'(2), '0);
    offer_request(REQ_READ, ClusterW'(3), '1);
    offer_request(REQ_READ, ClusterW'(TableEntries - 1), '0);
    // first fit hands out 3 then 4
    offer_request(REQ_ALLOC, '1, '1);
    offer_request(REQ_ALLOC, '0, '0);
    // upper four value bits are dropped
    offer_request(REQ_SET, ClusterW'(TableEntries - 1), '1);
    offer_request(REQ_READ, ClusterW'(TableEntries - 1), '0);
    // chain running past the table end
    offer_request(REQ_SET, ClusterW'(5), 32'hF000_0006);
    offer_request(REQ_SET, ClusterW'(6), 32'h0000_1000);
    offer_request(REQ_FREE, ClusterW'(5), '0);
    // freeing cluster 0 clears nothing
    offer_request(REQ_FREE, ClusterW'(0), '0);
    // two-entry loop: first entry is cleared and counted twice
    offer_request(REQ_SET, ClusterW'(7), 32'd8);
    offer_request(REQ_SET, ClusterW'(8), 32'd7);
    offer_request(REQ_FREE, ClusterW'(7), '0);
    // chain ending in a bad-cluster code
    offer_request(REQ_SET, ClusterW'(9), 32'h0FFF_FFF9);
    offer_request(REQ_SET, ClusterW'(10), 32'd9);
    offer_request(REQ_FREE, ClusterW'(10), '0);
    // reserved entries behave like any other
    offer_request(REQ_FREE, ClusterW'(1), '0);
    offer_request(REQ_SET, ClusterW'(0), 32'h5000_0000);
    offer_request(REQ_READ, ClusterW'(0), '0);
    offer_request(REQ_FREE, ClusterW'(TableEntries - 1), '0);
  endtask

  function automatic logic [TotalW-1:0] total_for_phase(input int unsigned phase);
    case (phase)
      1: return '0;
      2: return '1;
      3: return TotalW'(1);
      4: return TotalW'($urandom_range(2, 40));
      5: return TotalW'($urandom_range(41, 400));
      6: return TotalW'(3);
      default: return TotalReset;
    endcase
  endfunction

  // Chains with random content on about two picks in five, the rest single requests
  task automatic run_mixed_traffic(input int unsigned phase, input int unsigned target);
    int unsigned pick;
    int unsigned midpoint;
    bit          pressed;
    bit          ok;
    midpoint = target - ItemsPerPhase / 2;
    pressed  = 1'b0;
    if (phase == PhaseCount - 1) begin
      build_and_free_chain(LongChain);
    end
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        build_and_free_chain(($urandom_range(0, 39) == 0) ? $urandom_range(64, 400)
                                                           : $urandom_range(1, ShortChainMax));
      end else if (pick < 62) begin
        offer_request(REQ_ALLOC, ClusterW'($urandom()), $urandom());
      end else if (pick < 76) begin
        offer_request(REQ_READ, ClusterW'($urandom()), $urandom());
      end else if (pick < 90) begin
        offer_request(REQ_SET, ClusterW'($urandom()), $urandom());
      end else begin
        offer_request(REQ_FREE, ClusterW'($urandom()), $urandom());
      end
      if (!pressed && items_sent >= midpoint) begin
        pressed = 1'b1;
        // receiver goes quiet while requests keep coming
        if (phase == HoldPhase) begin
          rsp_hold_len = HoldCycles;
        end
        // sender stops until the block has answered everything
        if (phase == PausePhase) begin
          wait_for_all_words(ok);
          all_drained = all_drained && ok;
        end
      end
    end
  endtask

  // Response side: random stalls, one long hold-off on request
  initial begin : rsp_sink
    int unsigned stall;
    stall = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        shadow.compare_word(rsp_if.result_value, rsp_if.status, rsp_if.freed_count);
      end
      if (stall == 0 && rsp_hold_len != 0) begin
        stall        = rsp_hold_len;
        rsp_hold_len = 0;
        holdoffs_done++;
      end else if (stall == 0 && $urandom_range(0, 99) < rsp_idle_pct) begin
        stall = pick_gap();
      end
      if (stall != 0) begin
        stall--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Overall run limit, far above the slowest expected run
  initial begin : run_limit
    #40_000_000;
    $display("run limit hit, %0d words outstanding", shadow.pending_words.size());
    $display("FAIL");
    $finish;
  end

  // Main sequence: reset, directed checks, then one traffic phase per setting
  initial begin : stimulus
    bit          ok;
    int unsigned phase;
    shadow        = new();
    items_sent    = 0;
    rsp_hold_len  = 0;
    holdoffs_done = 0;
    all_drained   = 1'b1;
    req_gap_pct   = 20;
    rsp_idle_pct  = 6;
    rst_ni               <= 1'b0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    req_if.valid         <= 1'b0;
    req_if.req_type      <= REQ_READ;
    req_if.cluster_index <= '0;
    req_if.link_value    <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_directed_checks();
    for (phase = 0; phase < PhaseCount; phase++) begin
      if (phase != 0) begin
        wait_for_all_words(ok);
        all_drained = all_drained && ok;
        program_total(total_for_phase(phase));
      end
      // every third phase runs with no idling on either side
      req_gap_pct  = (phase % 3 == 2) ? 0 : 30;
      rsp_idle_pct = (phase % 3 == 2) ? 0 : 8;
      run_mixed_traffic(phase, items_sent + ItemsPerPhase);
    end

    wait_for_all_words(ok);
    all_drained = all_drained && ok;
    repeat (TailCycles) @(posedge clk_i);
    if (!all_drained || shadow.pending_words.size() != 0) begin
      shadow.flag($sformatf("response words late or missing, %0d still expected",
                            shadow.pending_words.size()));
    end

    $display("%0d requests: read %0d, set %0d, allocate %0d, free %0d; %0d APB settings",
             items_sent, shadow.kind_seen[REQ_READ], shadow.kind_seen[REQ_SET],
             shadow.kind_seen[REQ_ALLOC], shadow.kind_seen[REQ_FREE], PhaseCount - 1);
    $display("%0d words checked: ok %0d, no free %0d, range %0d, limit %0d; %s %0d; %0d errors",
             shadow.words_checked, shadow.status_seen[ST_OK], shadow.status_seen[ST_NOFREE],
             shadow.status_seen[ST_RANGE], shadow.status_seen[ST_LIMIT],
             "longest free", shadow.longest_free, shadow.mismatches);
    if (shadow.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
